### rtl/spq_pkg.sv
// Shared types, widths and codes for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int DATA_W    = 32;
   localparam int OCC_W     = 5;
   localparam int STATUS_W  = 2;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] prio;
      logic signed [DATA_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] out_value;
      logic signed [DATA_W-1:0] out_priority;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

endpackage

### rtl/spq_store.sv
// Entry memory of the queue with one write port and one registered read port.
`timescale 1ns / 1ps
module spq_store #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  spq_pkg::entry_type             wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output spq_pkg::entry_type             rd_data
);
   import spq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/spq_ctrl.sv
// Sequencer that inserts and removes entries one memory slot at a time.
`timescale 1ns / 1ps
module spq_ctrl #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_command,
   input  logic signed [spq_pkg::DATA_W-1:0] req_in_value,
   input  logic signed [spq_pkg::DATA_W-1:0] req_in_priority,
   output logic                              req_stall,
   output logic                              wr_en,
   output logic [$clog2(DEPTH)-1:0]          wr_addr,
   output spq_pkg::entry_type                wr_data,
   output logic [$clog2(DEPTH)-1:0]          rd_addr,
   input  spq_pkg::entry_type                rd_data,
   output logic                              fin_valid,
   output spq_pkg::rsp_type                  fin_res,
   input  logic                              out_free
);
   import spq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ERD  = 3'd1;
   localparam logic [2:0] S_ECMP = 3'd2;
   localparam logic [2:0] S_DRD  = 3'd3;
   localparam logic [2:0] S_DWR  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   entry_type        new_ff, new_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [DATA_W-1:0] head_val_ff, head_val_in;
   logic signed [DATA_W-1:0] head_pri_ff, head_pri_in;
   logic [CNT_W-1:0] idx_dec;
   logic [CNT_W-1:0] idx_inc;

   assign idx_dec = idx_ff - CNT_ONE;
   assign idx_inc = idx_ff + CNT_ONE;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      new_in      = new_ff;
      status_in   = status_ff;
      head_val_in = head_val_ff;
      head_pri_in = head_pri_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_data     = new_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      fin_valid   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_in.value = req_in_value;
               new_in.prio  = req_in_priority;
               status_in    = STATUS_DONE;
               head_val_in  = '0;
               head_pri_in  = '0;
               if (req_command == CMD_ENQ) begin
                  if (cnt_ff >= FULL_CNT) begin
                     status_in = STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = S_ERD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     idx_in   = '0;
                     state_in = S_DRD;
                  end
               end
            end
         end
         S_ERD: begin
            rd_addr = idx_dec[IDX_W-1:0];
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               cnt_in   = cnt_ff + CNT_ONE;
               state_in = S_DONE;
            end else begin
               state_in = S_ECMP;
            end
         end
         S_ECMP: begin
            wr_en = 1'b1;
            if (new_ff.prio < rd_data.prio) begin
               wr_data  = rd_data;
               idx_in   = idx_dec;
               state_in = S_ERD;
            end else begin
               cnt_in   = cnt_ff + CNT_ONE;
               state_in = S_DONE;
            end
         end
         S_DRD: begin
            state_in = S_DWR;
         end
         S_DWR: begin
            wr_addr = idx_dec[IDX_W-1:0];
            wr_data = rd_data;
            if (idx_ff == '0) begin
               head_val_in = rd_data.value;
               head_pri_in = rd_data.prio;
            end else begin
               wr_en = 1'b1;
            end
            idx_in = idx_inc;
            if (idx_inc < cnt_ff) begin
               state_in = S_DRD;
            end else begin
               cnt_in   = cnt_ff - CNT_ONE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            fin_valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      status_ff   <= status_in;
      head_val_ff <= head_val_in;
      head_pri_ff <= head_pri_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign fin_res.status       = status_ff;
   assign fin_res.out_value    = head_val_ff;
   assign fin_res.out_priority = head_pri_ff;
   assign fin_res.occupancy    = OCC_W'(cnt_ff);

endmodule

### rtl/sorted_priority_queue_top.sv
// Sorted priority queue: memory, sequencer and result register.
//
// The req_ channel carries one command per item: enqueue a value with a
// signed priority, or dequeue the entry with the smallest priority number.
// Entries of equal priority leave in arrival order. Each accepted item
// gives exactly one item on the rsp_ channel with a status, the removed
// value and priority (zero unless a dequeue succeeded) and the occupancy.
// The block works on one item at a time and holds req_stall high until
// that item's result has entered the output register. Every entry moved
// costs a read and then a write of the entry memory; an enqueue also
// compares priorities in the write step. A waiting result in the output
// register does not block a new item; if rsp_stall holds it, the next
// result waits in the sequencer. Reset empties the queue and drops any
// pending result; memory is not cleared.
`timescale 1ns / 1ps
module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_in_value,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_in_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_out_value,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]           rsp_occupancy
);
   import spq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             fin_valid;
   rsp_type          fin_res;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   spq_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_command     (req_command),
      .req_in_value    (req_in_value),
      .req_in_priority (req_in_priority),
      .req_stall       (req_stall),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .fin_valid       (fin_valid),
      .fin_res         (fin_res),
      .out_free        (out_free)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = fin_valid;
         if (fin_valid) begin
            rsp_in = fin_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_out_value    = rsp_ff.out_value;
   assign rsp_out_priority = rsp_ff.out_priority;
   assign rsp_occupancy    = rsp_ff.occupancy;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sequencer took an item without going busy");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      fin_valid && out_free |=> rsp_valid_ff && rsp_ff == $past(fin_res))
      else $error("finished result was not loaded into the output register");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      fin_valid && fin_res.status != STATUS_DONE |->
         fin_res.out_value == '0 && fin_res.out_priority == '0)
      else $error("rejected item carries a nonzero value or priority");

endmodule
